@@ src/position_frame_parser_scaler_core_macros.svh @@
// ----------------------------------------------------------------------------
// position frame parser scaler assertion macros
// shared property wrappers, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef POSITION_FRAME_PARSER_SCALER_CORE_MACROS_SVH
`define POSITION_FRAME_PARSER_SCALER_CORE_MACROS_SVH

// condition must hold at every edge
`define PFPS_CHECK_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition must hold in the cycle after the trigger
`define PFPS_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

@@ src/pfps_pkg.sv @@
// ----------------------------------------------------------------------------
// pfps_pkg
// constants and types shared by the position frame parser and scaler
// ----------------------------------------------------------------------------
package pfps_pkg;

  // field widths
  localparam int RAW_W   = 16;
  localparam int RANGE_W = 20;
  localparam int MASK_W  = 7;
  localparam int PROD_W  = RAW_W + RANGE_W;
  localparam int CFG_IDX_W = 8;

  // frame marker bytes
  localparam logic [7:0] BYTE_START1 = 8'h59;
  localparam logic [7:0] BYTE_START2 = 8'h37;
  localparam logic [7:0] BYTE_END    = 8'h21;

  // full scale of a raw position
  localparam logic [RAW_W-1:0] RAW_FULL = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_MASK  = 8'd3;

  // scaler status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

endpackage

@@ src/pfps_parser.sv @@
// ----------------------------------------------------------------------------
// pfps_parser
// byte framing state machine and raw position store
// ----------------------------------------------------------------------------
module pfps_parser #(
  parameter int AXES = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  input  logic [7:0]                     rx_byte,
  output logic                           frame_ok,
  input  logic [((AXES > 1) ? $clog2(AXES) : 1)-1:0] rd_addr,
  output logic [pfps_pkg::RAW_W-1:0]     rd_data
);

  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int FP_W = $clog2(2 * AXES + 4);

  localparam logic [FP_W-1:0] P_HUNT   = FP_W'(0);
  localparam logic [FP_W-1:0] P_START2 = FP_W'(1);
  localparam logic [FP_W-1:0] P_DATA   = FP_W'(2);
  localparam logic [FP_W-1:0] P_END1   = FP_W'(2 + 2 * AXES);
  localparam logic [FP_W-1:0] P_END2   = FP_W'(3 + 2 * AXES);

  logic [FP_W-1:0]            fp;
  logic [7:0]                 hold;
  logic                       end_ok;
  logic [FP_W-1:0]            off;
  logic [AX_W-1:0]            ax;
  logic                       in_data;
  logic [pfps_pkg::RAW_W-1:0] raw_mem [AXES];

  // offset inside the position bytes
  assign off     = fp - P_DATA;
  assign ax      = off[AX_W:1];
  assign in_data = (fp >= P_DATA) && (fp < P_END1);

  // good second end mark closes the frame
  assign frame_ok = byte_valid && (fp == P_END2) && end_ok && (rx_byte == pfps_pkg::BYTE_END);

  // frame position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      fp     <= P_HUNT;
      hold   <= '0;
      end_ok <= 1'b0;
    end else if (byte_valid) begin
      if (fp == P_HUNT) begin
        if (rx_byte == pfps_pkg::BYTE_START1) fp <= P_START2;
      end else if (fp == P_START2) begin
        fp <= (rx_byte == pfps_pkg::BYTE_START2) ? P_DATA : P_HUNT;
      end else if (in_data) begin
        if (!off[0]) hold <= rx_byte;
        fp <= fp + FP_W'(1);
      end else if (fp == P_END1) begin
        end_ok <= (rx_byte == pfps_pkg::BYTE_END);
        fp     <= P_END2;
      end else begin
        end_ok <= 1'b0;
        fp     <= P_HUNT;
      end
    end
  end

  // raw position store, low byte completes an entry
  always_ff @(posedge clk) begin
    if (byte_valid && in_data && off[0]) raw_mem[ax] <= {hold, rx_byte};
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= raw_mem[rd_addr];
  end

endmodule

@@ src/pfps_scaler.sv @@
// ----------------------------------------------------------------------------
// pfps_scaler
// bit-serial multiply by span, bit-serial divide by full scale, offset and clamp
// ----------------------------------------------------------------------------
`include "position_frame_parser_scaler_core_macros.svh"

module pfps_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pfps_pkg::RAW_W-1:0]    raw,
  input  logic [pfps_pkg::RANGE_W-1:0]  range_low,
  input  logic [pfps_pkg::RANGE_W-1:0]  range_high,
  output pfps_pkg::scl_stat_t           stat,
  output logic [pfps_pkg::RANGE_W-1:0]  target
);

  localparam int RAW_W   = pfps_pkg::RAW_W;
  localparam int RANGE_W = pfps_pkg::RANGE_W;
  localparam int PROD_W  = pfps_pkg::PROD_W;
  localparam int CNT_W   = $clog2(PROD_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic [RAW_W-1:0]     raw_sr;
  logic [RANGE_W-1:0]   span;
  logic [RANGE_W-1:0]   lo;
  logic [RANGE_W-1:0]   hi;
  logic                 inv;
  logic [PROD_W-1:0]    acc;
  logic [RAW_W-1:0]     rem;
  logic [RANGE_W-1:0]   quo;
  logic [PROD_W-1:0]    acc_sum;
  logic [RAW_W:0]       div_trial;
  logic                 div_ge;
  logic [RAW_W:0]       div_rem;
  logic [RANGE_W:0]     offs_sum;
  logic [RANGE_W-1:0]   result;

  // multiply step, msb of raw first
  assign acc_sum = {acc[PROD_W-2:0], 1'b0} + (raw_sr[RAW_W-1] ? PROD_W'(span) : '0);

  // restoring divide step by full scale
  assign div_trial = {rem, acc[PROD_W-1]};
  assign div_ge    = div_trial >= {1'b0, pfps_pkg::RAW_FULL};
  assign div_rem   = div_ge ? (div_trial - {1'b0, pfps_pkg::RAW_FULL}) : div_trial;

  // offset and clamp
  assign offs_sum = {1'b0, quo} + {1'b0, lo};
  always_comb begin
    if (inv) begin
      result = lo;
    end else if (offs_sum > {1'b0, hi}) begin
      result = hi;
    end else begin
      result = offs_sum[RANGE_W-1:0];
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MUL;
            cnt   <= CNT_W'(RAW_W - 1);
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            state <= S_DIV;
            cnt   <= CNT_W'(PROD_W - 1);
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_DIV: begin
          if (cnt == '0) state <= S_FIN;
          else cnt <= cnt - CNT_W'(1);
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          raw_sr <= raw;
          lo     <= range_low;
          hi     <= range_high;
          span   <= range_high - range_low;
          inv    <= range_high < range_low;
          acc    <= '0;
          rem    <= '0;
          quo    <= '0;
        end
      end
      S_MUL: begin
        acc    <= acc_sum;
        raw_sr <= {raw_sr[RAW_W-2:0], 1'b0};
      end
      S_DIV: begin
        acc <= {acc[PROD_W-2:0], 1'b0};
        rem <= div_rem[RAW_W-1:0];
        quo <= {quo[RANGE_W-2:0], div_ge};
      end
      S_FIN: target <= result;
      default: begin
      end
    endcase
  end

  `PFPS_CHECK_NOW(a_start_only_idle, !start || !stat.busy, "scaler started while busy")
  `PFPS_CHECK_NOW(a_target_in_range, !stat.done || ((target >= lo) && (inv || (target <= hi))), "target outside range")
  `PFPS_CHECK_NEXT(a_fin_gives_done, state == S_FIN, stat.done, "no done after finish")

endmodule

@@ src/position_frame_parser_scaler_core.sv @@
// ----------------------------------------------------------------------------
// position_frame_parser_scaler_core
// frames received bytes into axis positions and issues scaled step targets
// ----------------------------------------------------------------------------
// usage
//   rx channel (rx_valid/rx_ready/rx_byte): one received byte per request.
//   while no frame results are pending a byte is taken every cycle.
//   out channel (out_valid/out_ready): one result per axis, axis order,
//   last set on the final axis. results sit in an output register.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready,
//   index 0 range_low, 1 range_high, 2 enable_mask, 3 ready_mask;
//   other indexes are ignored.
//   after the good closing byte of a frame rx_ready drops; each axis passes
//   through a read step, a load step, the multiply and divide steps, a finish
//   step and a done step in the shared bit-serial scaler before its result shows.
//   a stalled receiver holds the result and the block;
//   rx_ready returns the cycle after the last result is taken.
//   reset: synchronous, restores register defaults and hunts for a start.
// ----------------------------------------------------------------------------
`include "position_frame_parser_scaler_core_macros.svh"

module position_frame_parser_scaler_core #(
  parameter int AXES = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rx_valid,
  output logic                                rx_ready,
  input  logic [7:0]                          rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          axis_index,
  output logic [pfps_pkg::RANGE_W-1:0]        target_step,
  output logic                                apply,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfps_pkg::RANGE_W-1:0]        cfg_data
);

  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_READ = 5'b00010,
    T_LOAD = 5'b00100,
    T_CALC = 5'b01000,
    T_OUT  = 5'b10000
  } state_t;

  state_t                        state;
  logic [AX_W-1:0]               axis_cnt;
  logic [4:0]                    axis_w;
  logic                          axis_app;
  logic                          frame_ok;
  logic                          rx_take;
  logic [pfps_pkg::RAW_W-1:0]    raw_rd;
  logic [pfps_pkg::RANGE_W-1:0]  scl_target;
  pfps_pkg::scl_stat_t           scl_stat;
  logic [pfps_pkg::RANGE_W-1:0]  range_low;
  logic [pfps_pkg::RANGE_W-1:0]  range_high;
  logic [pfps_pkg::MASK_W-1:0]   enable_mask;
  logic [pfps_pkg::MASK_W-1:0]   ready_mask;

  assign rx_ready  = (state == T_IDLE);
  assign rx_take   = rx_valid && rx_ready;
  assign out_valid = (state == T_OUT);
  assign cfg_ready = 1'b1;

  // axes past the masks never apply
  assign axis_w   = 5'(axis_cnt);
  assign axis_app = (axis_w < 5'd7) ? (enable_mask[axis_w[2:0]] & ready_mask[axis_w[2:0]])
                                    : 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= 20'd200;
      range_high  <= 20'd19800;
      enable_mask <= 7'd127;
      ready_mask  <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfps_pkg::CFG_RANGE_LOW:   range_low   <= cfg_data;
        pfps_pkg::CFG_RANGE_HIGH:  range_high  <= cfg_data;
        pfps_pkg::CFG_ENABLE_MASK: enable_mask <= cfg_data[pfps_pkg::MASK_W-1:0];
        pfps_pkg::CFG_READY_MASK:  ready_mask  <= cfg_data[pfps_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame parser and position store
  pfps_parser #(.AXES(AXES)) u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (rx_take),
    .rx_byte    (rx_byte),
    .frame_ok   (frame_ok),
    .rd_addr    (axis_cnt),
    .rd_data    (raw_rd)
  );

  // shared serial scaler
  pfps_scaler u_scaler (
    .clk        (clk),
    .rst        (rst),
    .start      (state == T_LOAD),
    .raw        (raw_rd),
    .range_low  (range_low),
    .range_high (range_high),
    .stat       (scl_stat),
    .target     (scl_target)
  );

  // per axis result sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      axis_cnt <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (frame_ok) begin
            state    <= T_READ;
            axis_cnt <= '0;
          end
        end
        T_READ: state <= T_LOAD;
        T_LOAD: state <= T_CALC;
        T_CALC: begin
          if (scl_stat.done) state <= T_OUT;
        end
        T_OUT: begin
          if (out_ready) begin
            if (last) begin
              state <= T_IDLE;
            end else begin
              state    <= T_READ;
              axis_cnt <= AX_W'(axis_cnt + 1'b1);
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == T_CALC && scl_stat.done) begin
      axis_index  <= axis_w[2:0];
      target_step <= scl_target;
      apply       <= axis_app;
      last        <= (axis_cnt == AX_W'(AXES - 1));
    end
  end

  `PFPS_CHECK_NOW(a_no_rx_with_result, !(rx_ready && out_valid), "byte taken while result pending")
  `PFPS_CHECK_NEXT(a_frame_blocks_rx, frame_ok, !rx_ready, "rx still ready after frame close")
  `PFPS_CHECK_NEXT(a_last_frees_rx, out_valid && out_ready && last, rx_ready, "rx not ready after last result")

endmodule
